@@ rtl/core/hit_pkg.sv @@
// ---------------------------------------------------------------------------
// hit_pkg: shared types and constants of the hash intern table
// Holds the stream field widths, the djb2 hash constants, the result
// status codes and the request bundle passed to the home slot unit.
// ---------------------------------------------------------------------------
`default_nettype none

package hit_pkg;

    // Defaults for the top level parameters
    localparam int DEF_TABLE_SIZE = 511;
    localparam int DEF_KEY_BYTES  = 8;

    // Fixed field widths
    localparam int KEY_TEXT_W = 64;
    localparam int KEY_LEN_W  = 4;
    localparam int IN_DATA_W  = 72;   // 68 payload bits rounded up to bytes

    // djb2 hash: h = h * 33 + c, starting at 5381
    localparam int          HASH_W          = 32;
    localparam logic [31:0] DJB2_START      = 32'd5381;
    localparam int          DJB2_MULT_SHIFT = 5;   // 33 = 2^5 + 1

    // Result status codes
    typedef enum logic [1:0] {
        STAT_FOUND = 2'd0,
        STAT_ADDED = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // Request to the home slot unit
    typedef struct packed {
        logic                  start;
        logic [KEY_LEN_W-1:0]  len;    // already limited to the key size
        logic [KEY_TEXT_W-1:0] text;   // already masked to the length
    } home_req_t;

endpackage

`default_nettype wire

@@ rtl/core/hit_home_slot.sv @@
// ---------------------------------------------------------------------------
// hit_home_slot: djb2 hash and home slot of a key
// Hashes one character per cycle, then reduces the 32-bit hash modulo
// TABLE_SIZE with a reciprocal multiply split into two 16-bit halves, a
// back multiply, a subtract and one compare-subtract correction.
// ---------------------------------------------------------------------------
`default_nettype none

module hit_home_slot #(
    parameter int TABLE_SIZE = hit_pkg::DEF_TABLE_SIZE
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire hit_pkg::home_req_t            req,
    output logic                               done,
    output logic [$clog2(TABLE_SIZE)-1:0]      slot
);

    localparam int SLOT_W  = $clog2(TABLE_SIZE);
    localparam int REM_W   = SLOT_W + 1;
    localparam int SHIFT   = hit_pkg::HASH_W + SLOT_W;
    localparam int RECIP_W = 33;
    localparam int PROD_W  = 16 + RECIP_W;
    localparam int SUM_W   = PROD_W + 16;
    // floor(2^SHIFT / N): quotient estimate is low by at most one
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'(1) << SHIFT) / 64'(TABLE_SIZE));
    localparam logic [31:0]      MODULUS   = 32'(TABLE_SIZE);
    localparam logic [REM_W-1:0] MODULUS_R = REM_W'(TABLE_SIZE);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HASH,
        PH_MUL_LO,
        PH_MUL_HI,
        PH_QUOT,
        PH_BACK,
        PH_REM,
        PH_FIX
    } phase_t;

    phase_t                           phase_reg;
    logic [hit_pkg::KEY_LEN_W-1:0]    len_reg;
    logic [hit_pkg::KEY_LEN_W-1:0]    cnt_reg;
    logic [hit_pkg::KEY_TEXT_W-1:0]   text_reg;
    logic [31:0]                      hash_reg;
    logic [PROD_W-1:0]                prod_lo_reg;
    logic [PROD_W-1:0]                prod_hi_reg;
    logic [31:0]                      quot_reg;
    logic [31:0]                      back_reg;
    logic [REM_W-1:0]                 rem_reg;
    logic                             done_reg;
    logic [SLOT_W-1:0]                slot_reg;

    logic [31:0]       hash_next;
    logic [SUM_W-1:0]  prod_sum;

    // Next hash value: h * 33 + c
    assign hash_next = (hash_reg << hit_pkg::DJB2_MULT_SHIFT) + hash_reg
                     + {24'd0, text_reg[7:0]};
    assign prod_sum  = SUM_W'(prod_lo_reg) + (SUM_W'(prod_hi_reg) << 16);

    // Sequence hash and reduction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            // Pulse done as the slot is loaded
            done_reg <= (phase_reg == PH_FIX);
            case (phase_reg)
                PH_IDLE:
                begin
                    if (req.start)
                    begin
                        len_reg   <= req.len;
                        text_reg  <= req.text;
                        cnt_reg   <= '0;
                        hash_reg  <= hit_pkg::DJB2_START;
                        phase_reg <= PH_HASH;
                    end
                end
                PH_HASH:
                begin
                    if (cnt_reg == len_reg)
                    begin
                        phase_reg <= PH_MUL_LO;
                    end
                    else
                    begin
                        hash_reg <= hash_next;
                        text_reg <= text_reg >> 8;
                        cnt_reg  <= cnt_reg + 1'b1;
                    end
                end
                PH_MUL_LO:
                begin
                    prod_lo_reg <= PROD_W'(hash_reg[15:0]) * PROD_W'(RECIP);
                    phase_reg   <= PH_MUL_HI;
                end
                PH_MUL_HI:
                begin
                    prod_hi_reg <= PROD_W'(hash_reg[31:16]) * PROD_W'(RECIP);
                    phase_reg   <= PH_QUOT;
                end
                PH_QUOT:
                begin
                    quot_reg  <= 32'(prod_sum >> SHIFT);
                    phase_reg <= PH_BACK;
                end
                PH_BACK:
                begin
                    back_reg  <= 32'(quot_reg * MODULUS);
                    phase_reg <= PH_REM;
                end
                PH_REM:
                begin
                    rem_reg   <= REM_W'(hash_reg - back_reg);
                    phase_reg <= PH_FIX;
                end
                PH_FIX:
                begin
                    // Fold the remainder into range once
                    if (rem_reg >= MODULUS_R)
                    begin
                        slot_reg <= SLOT_W'(rem_reg - MODULUS_R);
                    end
                    else
                    begin
                        slot_reg <= SLOT_W'(rem_reg);
                    end
                    phase_reg <= PH_IDLE;
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign slot = slot_reg;

endmodule

`default_nettype wire

@@ rtl/core/hash_intern_table_core.sv @@
// ---------------------------------------------------------------------------
// hash_intern_table_core: find-or-insert key table with linear probing
// Hashes each key with djb2, probes a single-port table memory from the
// home slot, and either finds the key, adds it in the first empty slot,
// or reports a full table. Also flags a fill above three quarters.
// ---------------------------------------------------------------------------
//
//  Channel | Dir | Transaction                   | tdata fields (low bit up)
//  --------+-----+-------------------------------+----------------------------
//  s_*     | in  | one key lookup request        | key_text[63:0], key_length[3:0]
//  m_*     | out | one result per request        | slot, status[1:0], load_high
//
// Each request runs in order: the key is hashed with djb2, the hash is reduced
// modulo TABLE_SIZE, the home slot is taken, every probed slot is read and then
// compared, and the result is loaded into the output register; s_tready rises
// as that register is loaded. After reset a clearing pass marks every slot
// empty with s_tready low. A result waits in the output register; a new one
// stalls only while the old one is not taken.
// ---------------------------------------------------------------------------
`default_nettype none

module hash_intern_table_core #(
    parameter int TABLE_SIZE = hit_pkg::DEF_TABLE_SIZE,
    parameter int KEY_BYTES  = hit_pkg::DEF_KEY_BYTES
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // key_text[63:0], key_length[67:64], zero pad
    input  wire logic [hit_pkg::IN_DATA_W-1:0]        s_tdata,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // slot, status, load_high, zero pad
    output logic [(($clog2(TABLE_SIZE) + 3 + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready
);

    localparam int SLOT_W    = $clog2(TABLE_SIZE);
    localparam int OUT_W     = ((SLOT_W + 3 + 7) / 8) * 8;
    localparam int FILL_W    = $clog2(TABLE_SIZE + 1);
    localparam int KEY_W     = 8 * KEY_BYTES;
    localparam int LEN_W     = hit_pkg::KEY_LEN_W;
    localparam int ENT_W     = 1 + LEN_W + KEY_W;
    localparam int HIGH_MARK = TABLE_SIZE * 3 / 4;
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(TABLE_SIZE - 1);
    localparam logic [LEN_W-1:0]  MAX_LEN    = LEN_W'(KEY_BYTES);
    localparam logic [FILL_W-1:0] HIGH_FILL  = FILL_W'(HIGH_MARK);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HOME,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    state_t                         state_reg;
    logic [SLOT_W-1:0]              idx_reg;
    logic [SLOT_W-1:0]              probe_reg;
    logic [FILL_W-1:0]              fill_reg;
    logic [LEN_W-1:0]               len_reg;
    logic [KEY_W-1:0]               key_reg;
    logic [SLOT_W-1:0]              res_slot_reg;
    hit_pkg::status_t               res_status_reg;
    logic                           out_valid_reg;
    logic [SLOT_W-1:0]              out_slot_reg;
    hit_pkg::status_t               out_status_reg;
    logic                           out_high_reg;

    // Table memory: {valid, length, key}
    logic [ENT_W-1:0]               mem [TABLE_SIZE];
    logic [ENT_W-1:0]               rd_data_reg;
    logic                           mem_we;
    logic [ENT_W-1:0]               mem_wdata;

    logic [LEN_W-1:0]               in_len;
    logic [LEN_W-1:0]               len_sat;
    logic [hit_pkg::KEY_TEXT_W-1:0] text_masked;
    logic                           in_accept;
    hit_pkg::home_req_t             home_req;
    logic                           home_done;
    logic [SLOT_W-1:0]              home_slot;
    logic                           rd_valid;
    logic [LEN_W-1:0]               rd_len;
    logic [KEY_W-1:0]               rd_key;
    logic                           out_free;

    // Limit the length and clear bytes beyond it
    assign in_len  = s_tdata[hit_pkg::KEY_TEXT_W +: LEN_W];
    assign len_sat = (in_len > MAX_LEN) ? MAX_LEN : in_len;

    always_comb
    begin
        text_masked = '0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            if (LEN_W'(i) < len_sat)
            begin
                text_masked[8*i +: 8] = s_tdata[8*i +: 8];
            end
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign home_req.start = in_accept;
    assign home_req.len   = len_sat;
    assign home_req.text  = text_masked;

    hit_home_slot #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_home_slot (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (home_req),
        .done  (home_done),
        .slot  (home_slot)
    );

    // Split the read entry
    assign rd_valid = rd_data_reg[ENT_W-1];
    assign rd_len   = rd_data_reg[KEY_W +: LEN_W];
    assign rd_key   = rd_data_reg[KEY_W-1:0];

    // Write on the clearing pass and on an insert
    assign mem_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_CHECK) && !rd_valid);
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : {1'b1, len_reg, key_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= mem_wdata;
        end
        rd_data_reg <= mem[idx_reg];
    end

    assign out_free = !out_valid_reg || m_tready;

    // Control sequence and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop a taken result unless a new one replaces it
            if (out_valid_reg && m_tready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    if (idx_reg == LAST_SLOT)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        len_reg   <= len_sat;
                        key_reg   <= text_masked[KEY_W-1:0];
                        state_reg <= ST_HOME;
                    end
                end
                ST_HOME:
                begin
                    if (home_done)
                    begin
                        idx_reg   <= home_slot;
                        probe_reg <= '0;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (!rd_valid)
                    begin
                        // Empty slot: store the key
                        fill_reg       <= fill_reg + 1'b1;
                        res_slot_reg   <= idx_reg;
                        res_status_reg <= hit_pkg::STAT_ADDED;
                        state_reg      <= ST_DONE;
                    end
                    else if ((rd_len == len_reg) && (rd_key == key_reg))
                    begin
                        res_slot_reg   <= idx_reg;
                        res_status_reg <= hit_pkg::STAT_FOUND;
                        state_reg      <= ST_DONE;
                    end
                    else if (probe_reg == LAST_SLOT)
                    begin
                        res_slot_reg   <= '0;
                        res_status_reg <= hit_pkg::STAT_FULL;
                        state_reg      <= ST_DONE;
                    end
                    else
                    begin
                        // Advance to the next slot with wrap
                        probe_reg <= probe_reg + 1'b1;
                        idx_reg   <= (idx_reg == LAST_SLOT) ? '0 : idx_reg + 1'b1;
                        state_reg <= ST_READ;
                    end
                end
                ST_DONE:
                begin
                    // Hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_slot_reg   <= res_slot_reg;
                        out_status_reg <= res_status_reg;
                        out_high_reg   <= (fill_reg > HIGH_FILL);
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_high_reg, out_status_reg, out_slot_reg});

endmodule

`default_nettype wire
